[design/fram_pkg.sv]
// Package for the four-register ALU machine: widths, action codes,
// decoded command and divider request/response types, back-end state.
// No dependencies.
package fram_pkg;

    localparam int DATA_W      = 32;
    localparam int ACTION_W    = 4;
    localparam int REG_FIELD_W = 2;
    localparam int REG_COUNT   = 4;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [DATA_W-1:0] INT_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    // Raw action codes as they arrive on the input channel
    localparam logic [ACTION_W-1:0] ACT_LOAD = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_READ = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_MOVE = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_ADD  = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_SUB  = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_MUL  = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_DIV  = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_MOD  = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_AND  = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_OR   = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_XOR  = 4'd10;
    localparam logic [ACTION_W-1:0] ACT_XCHG = 4'd11;

    typedef enum logic [2:0] {
        CLS_NOP,
        CLS_LOAD,
        CLS_READ,
        CLS_MOVE,
        CLS_ALU,
        CLS_DIV,
        CLS_XCHG
    } t_op_class;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_AND,
        ALU_OR,
        ALU_XOR
    } t_alu_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_DIV_OVF  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_XCHG,
        BK_DIV
    } t_back_state;

    typedef struct packed {
        t_op_class             cls;
        t_alu_op               alu_op;
        logic                  is_mod;
        logic [REG_IDX_W-1:0]  dest;
        logic [REG_IDX_W-1:0]  src;
        logic [DATA_W-1:0]     imm;
    } t_cmd;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } t_div_rsp;

endpackage

[design/fram_if.sv]
// Channel interfaces for the four-register ALU machine: instruction in,
// result out. Depends on fram_pkg.
interface fram_in_if import fram_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic [REG_FIELD_W-1:0]   dest_reg;
    logic [REG_FIELD_W-1:0]   src_reg;
    logic signed [DATA_W-1:0] immediate;

    modport source (output valid, action, dest_reg, src_reg, immediate, input ready);
    modport sink   (input valid, action, dest_reg, src_reg, immediate, output ready);
endinterface

interface fram_out_if import fram_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic                     is_output;
    logic [1:0]               status;

    modport source (output valid, read_value, is_output, status, input ready);
    modport sink   (input valid, read_value, is_output, status, output ready);
endinterface

[design/fram_front.sv]
// Front end: accepts instruction transactions and decodes them into
// command classes for the queue. Depends on fram_pkg and fram_if.
module fram_front import fram_pkg::*; (
    fram_in_if.sink i_cmd,
    input  logic    i_q_full,
    output logic    o_push,
    output t_cmd    o_push_cmd
);

    // Take a transaction whenever the queue has room
    assign i_cmd.ready = !i_q_full;
    assign o_push      = i_cmd.valid && !i_q_full;

    // Decode the raw action into class and sub-operation
    always_comb begin
        o_push_cmd.cls    = CLS_NOP;
        o_push_cmd.alu_op = ALU_ADD;
        o_push_cmd.is_mod = 1'b0;
        o_push_cmd.dest   = REG_IDX_W'(i_cmd.dest_reg % REG_COUNT);
        o_push_cmd.src    = REG_IDX_W'(i_cmd.src_reg % REG_COUNT);
        o_push_cmd.imm    = i_cmd.immediate;
        unique case (i_cmd.action)
            ACT_LOAD: o_push_cmd.cls = CLS_LOAD;
            ACT_READ: o_push_cmd.cls = CLS_READ;
            ACT_MOVE: o_push_cmd.cls = CLS_MOVE;
            ACT_ADD: begin
                o_push_cmd.cls    = CLS_ALU;
                o_push_cmd.alu_op = ALU_ADD;
            end
            ACT_SUB: begin
                o_push_cmd.cls    = CLS_ALU;
                o_push_cmd.alu_op = ALU_SUB;
            end
            ACT_MUL: begin
                o_push_cmd.cls    = CLS_ALU;
                o_push_cmd.alu_op = ALU_MUL;
            end
            ACT_AND: begin
                o_push_cmd.cls    = CLS_ALU;
                o_push_cmd.alu_op = ALU_AND;
            end
            ACT_OR: begin
                o_push_cmd.cls    = CLS_ALU;
                o_push_cmd.alu_op = ALU_OR;
            end
            ACT_XOR: begin
                o_push_cmd.cls    = CLS_ALU;
                o_push_cmd.alu_op = ALU_XOR;
            end
            ACT_DIV: o_push_cmd.cls = CLS_DIV;
            ACT_MOD: begin
                o_push_cmd.cls    = CLS_DIV;
                o_push_cmd.is_mod = 1'b1;
            end
            ACT_XCHG: o_push_cmd.cls = CLS_XCHG;
            default:  o_push_cmd.cls = CLS_NOP;
        endcase
    end

endmodule

[design/fram_queue.sv]
// Short command queue between front and back end.
// Depends on fram_pkg.
module fram_queue import fram_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Advance pointers with wrap, track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

[design/fram_div.sv]
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on fram_pkg.
module fram_div import fram_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_dsr;
    logic [DATA_W:0]      rem_shift;
    logic [DATA_W:0]      diff;
    logic                 fits;

    // Trial subtract of the shifted partial remainder
    assign rem_shift = {r_rem, r_quo[DATA_W-1]};
    assign diff      = rem_shift - {1'b0, r_dsr};
    assign fits      = !diff[DATA_W];

    // Sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Shift in one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], fits};
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

[design/fram_back.sv]
// Back end: register file, execution of decoded commands, output register.
// Depends on fram_pkg and fram_if.
module fram_back import fram_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_cmd        i_head,
    output logic        o_pop,
    output t_div_req    o_div_req,
    input  t_div_rsp    i_div_rsp,
    fram_out_if.source  o_res
);

    t_back_state          r_state, n_state;
    t_cmd                 r_cmd;
    logic [DATA_W-1:0]    r_rf [REG_COUNT];
    logic                 r_rf_vld [REG_COUNT];
    logic [DATA_W-1:0]    r_rd_a, r_rd_b;
    logic                 r_rd_a_vld, r_rd_b_vld;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_value;
    logic                 r_out_is_output;
    t_status              r_out_status;

    logic [DATA_W-1:0]    op_a, op_b;
    logic [DATA_W-1:0]    alu_res;
    logic [DATA_W-1:0]    abs_a, abs_b;
    logic [DATA_W-1:0]    div_res;
    logic                 div_zero, div_ovf;
    logic                 out_free;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_addr;
    logic [DATA_W-1:0]    wr_data;
    logic                 out_load;
    logic [DATA_W-1:0]    n_out_value;
    logic                 n_out_is_output;
    t_status              n_out_status;

    // Operands; an entry never written reads as zero
    assign op_a     = r_rd_a_vld ? r_rd_a : '0;
    assign op_b     = r_rd_b_vld ? r_rd_b : '0;
    assign out_free = !r_out_valid || o_res.ready;
    assign div_zero = (op_b == '0);
    assign div_ovf  = (op_a == INT_MIN) && (op_b == ALL_ONES);
    assign abs_a    = op_a[DATA_W-1] ? ('0 - op_a) : op_a;
    assign abs_b    = op_b[DATA_W-1] ? ('0 - op_b) : op_b;

    // Two-operand logic and arithmetic
    always_comb begin
        unique case (r_cmd.alu_op)
            ALU_ADD: alu_res = op_a + op_b;
            ALU_SUB: alu_res = op_a - op_b;
            ALU_MUL: alu_res = op_a * op_b;
            ALU_AND: alu_res = op_a & op_b;
            ALU_OR:  alu_res = op_a | op_b;
            ALU_XOR: alu_res = op_a ^ op_b;
            default: alu_res = '0;
        endcase
    end

    // Restore signs: quotient negative on differing signs, remainder follows dividend
    always_comb begin
        if (r_cmd.is_mod) begin
            div_res = op_a[DATA_W-1] ? ('0 - i_div_rsp.remainder) : i_div_rsp.remainder;
        end else if (op_a[DATA_W-1] ^ op_b[DATA_W-1]) begin
            div_res = '0 - i_div_rsp.quotient;
        end else begin
            div_res = i_div_rsp.quotient;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) n_state = BK_EXEC;
            end
            BK_EXEC: begin
                if (out_free) begin
                    if (r_cmd.cls == CLS_XCHG) begin
                        n_state = BK_XCHG;
                    end else if (r_cmd.cls == CLS_DIV && !div_zero && !div_ovf) begin
                        n_state = BK_DIV;
                    end else begin
                        n_state = BK_IDLE;
                    end
                end
            end
            BK_XCHG: n_state = BK_IDLE;
            BK_DIV: begin
                if (i_div_rsp.done && out_free) n_state = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // State outputs: pop, register write, divider start, result load
    always_comb begin
        o_pop              = 1'b0;
        wr_en              = 1'b0;
        wr_addr            = r_cmd.dest;
        wr_data            = '0;
        out_load           = 1'b0;
        n_out_value        = '0;
        n_out_is_output    = 1'b0;
        n_out_status       = ST_OK;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = abs_a;
        o_div_req.divisor  = abs_b;
        unique case (r_state)
            BK_IDLE: o_pop = !i_q_empty;
            BK_EXEC: begin
                if (out_free) begin
                    unique case (r_cmd.cls)
                        CLS_LOAD: begin
                            wr_en    = 1'b1;
                            wr_data  = r_cmd.imm;
                            out_load = 1'b1;
                        end
                        CLS_READ: begin
                            out_load        = 1'b1;
                            n_out_value     = op_a;
                            n_out_is_output = 1'b1;
                        end
                        CLS_MOVE: begin
                            wr_en    = 1'b1;
                            wr_data  = op_b;
                            out_load = 1'b1;
                        end
                        CLS_ALU: begin
                            wr_en    = 1'b1;
                            wr_data  = alu_res;
                            out_load = 1'b1;
                        end
                        CLS_XCHG: begin
                            wr_en    = 1'b1;
                            wr_data  = op_b;
                            out_load = 1'b1;
                        end
                        CLS_DIV: begin
                            if (div_zero) begin
                                out_load     = 1'b1;
                                n_out_status = ST_DIV_ZERO;
                            end else if (div_ovf) begin
                                wr_en        = 1'b1;
                                wr_data      = r_cmd.is_mod ? '0 : INT_MIN;
                                out_load     = 1'b1;
                                n_out_status = ST_DIV_OVF;
                            end else begin
                                o_div_req.start = 1'b1;
                            end
                        end
                        default: out_load = 1'b1;
                    endcase
                end
            end
            BK_XCHG: begin
                // Second half of an exchange: old destination into source
                wr_en   = 1'b1;
                wr_addr = r_cmd.src;
                wr_data = op_a;
            end
            BK_DIV: begin
                if (i_div_rsp.done && out_free) begin
                    wr_en    = 1'b1;
                    wr_data  = div_res;
                    out_load = 1'b1;
                end
            end
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the command and read both operands on pop
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd      <= i_head;
            r_rd_a     <= r_rf[i_head.dest];
            r_rd_b     <= r_rf[i_head.src];
            r_rd_a_vld <= r_rf_vld[i_head.dest];
            r_rd_b_vld <= r_rf_vld[i_head.src];
        end
    end

    // Register file write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_rf[wr_addr] <= wr_data;
        end
    end

    // Written flags; cleared entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_rf_vld[i] <= 1'b0;
            end
        end else if (wr_en) begin
            r_rf_vld[wr_addr] <= 1'b1;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value     <= n_out_value;
            r_out_is_output <= n_out_is_output;
            r_out_status    <= n_out_status;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.read_value = r_out_value;
    assign o_res.is_output  = r_out_is_output;
    assign o_res.status     = r_out_status;

`ifndef SYNTHESIS
    a_div_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |=> i_div_rsp.busy)
        else $error("divider not busy after start");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) |-> (i_div_rsp.busy || i_div_rsp.done))
        else $error("waiting on an idle divider");

    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !out_load)
        else $error("pending result overwritten");

    a_wr_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state != BK_IDLE))
        else $error("register write without a command");
`endif

endmodule

[design/four_register_alu_machine_top.sv]
// Top level of the four-register ALU machine: front decoder, command queue,
// back end with register file and iterative divider; uses all other design files.
//
//  Port     Dir  Protocol      Payload
//  i_cmd    in   valid/ready   action, dest_reg, src_reg, immediate
//  o_res    out  valid/ready   read_value, is_output, status
//
// Instructions pass a two-entry queue; the back end runs one at a time.
// Load, read, move, unused codes and ALU ops pass BK_IDLE and BK_EXEC; exchange
// adds BK_XCHG (second register write); a zero divisor or overflow case ends in
// BK_EXEC; divide/modulo waits in BK_DIV on the 32-step one-bit-per-cycle divider.
// Reset (i_rst_n low, synchronous) empties the queue and marks all registers
// unwritten, so they read as zero; there is no clearing pass.
// A stalled result holds in the output register while the queue keeps filling.
module four_register_alu_machine_top import fram_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    fram_in_if.sink     i_cmd,
    fram_out_if.source  o_res
);

    logic     q_push;
    t_cmd     q_push_cmd;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    t_cmd     q_head;
    t_div_req div_req;
    t_div_rsp div_rsp;

    fram_front u_front (
        .i_cmd      (i_cmd),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_push_cmd (q_push_cmd)
    );

    fram_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_empty    (q_empty),
        .o_head     (q_head)
    );

    fram_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    fram_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp),
        .o_res     (o_res)
    );

endmodule

[dv/four_register_alu_machine_top_tb.sv]
// Self-checking testbench for four_register_alu_machine_top: directed corner
// instructions, then random programs under several idle/stall mixes.
// Depends on fram_pkg, fram_if and the design top level.
module four_register_alu_machine_top_tb;
    import fram_pkg::*;

    // Action codes that the machine treats as no-ops
    localparam logic [ACTION_W-1:0] ACT_NONE_FIRST = 4'd12;
    localparam logic [ACTION_W-1:0] ACT_NONE_LAST  = 4'd15;

    localparam int STALL_LIMIT    = 3000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              is_output;
        t_status           status;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    fram_in_if  cmd_if ();
    fram_out_if res_if ();

    four_register_alu_machine_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // Shadow register file and the results it predicts, oldest first
    logic [DATA_W-1:0] arch_regs [REG_COUNT];
    t_result           pending_results [$];
    t_result           oldest_result;

    int mismatch_count;
    int quiet_cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int holdoff_left;
    bit holdoff_req;

    // Free-running clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Execute one instruction on the shadow registers and return its result
    function automatic t_result execute_instr(input logic [ACTION_W-1:0] act,
                                              input logic [REG_FIELD_W-1:0] dest,
                                              input logic [REG_FIELD_W-1:0] src,
                                              input logic [DATA_W-1:0] imm);
        t_result res;
        int unsigned di;
        int unsigned si;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;

        di = dest % REG_COUNT;
        si = src % REG_COUNT;
        a  = arch_regs[di];
        b  = arch_regs[si];
        res.read_value = '0;
        res.is_output  = 1'b0;
        res.status     = ST_OK;
        case (act) inside
            ACT_LOAD: arch_regs[di] = imm;
            ACT_READ: begin
                res.read_value = a;
                res.is_output  = 1'b1;
            end
            ACT_MOVE: arch_regs[di] = b;
            ACT_ADD:  arch_regs[di] = a + b;
            ACT_SUB:  arch_regs[di] = a - b;
            ACT_MUL:  arch_regs[di] = a * b;
            ACT_DIV, ACT_MOD: begin
                if (b == 0) begin
                    res.status = ST_DIV_ZERO;
                end else if (a == INT_MIN && b == ALL_ONES) begin
                    res.status    = ST_DIV_OVF;
                    arch_regs[di] = (act == ACT_DIV) ? INT_MIN : '0;
                end else begin
                    arch_regs[di] = (act == ACT_DIV) ? a / b : a % b;
                end
            end
            ACT_AND:  arch_regs[di] = a & b;
            ACT_OR:   arch_regs[di] = a | b;
            ACT_XOR:  arch_regs[di] = a ^ b;
            ACT_XCHG: begin
                arch_regs[di] = b;
                arch_regs[si] = a;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Predict on each accepted instruction, check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                pending_results.push_back(execute_instr(cmd_if.action, cmd_if.dest_reg,
                                                        cmd_if.src_reg, cmd_if.immediate));
            end
            if (res_if.valid && res_if.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with no instruction pending");
                    mismatch_count++;
                end else begin
                    oldest_result = pending_results.pop_front();
                    if (res_if.read_value !== oldest_result.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(oldest_result.read_value), res_if.read_value);
                        mismatch_count++;
                    end
                    if (res_if.is_output !== oldest_result.is_output) begin
                        $error("is_output: expected %0b, got %0b",
                               oldest_result.is_output, res_if.is_output);
                        mismatch_count++;
                    end
                    if (res_if.status !== oldest_result.status) begin
                        $error("status: expected %0d, got %0d",
                               oldest_result.status, res_if.status);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Drive ready: random stalls, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (holdoff_req) begin
            holdoff_req  = 1'b0;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left != 0) begin
            holdoff_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Abort when no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one instruction, idling first as the current mix asks
    task automatic issue_instr(input logic [ACTION_W-1:0] act,
                               input logic [REG_FIELD_W-1:0] dest,
                               input logic [REG_FIELD_W-1:0] src,
                               input logic [DATA_W-1:0] imm);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.action    <= act;
        cmd_if.dest_reg  <= dest;
        cmd_if.src_reg   <= src;
        cmd_if.immediate <= imm;
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    // Pick an operand value biased toward the division corners
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return INT_MIN;
            3:       return ~INT_MIN;
            4, 5:    return DATA_W'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    // Send a random program: many loads to refresh operands, a few unused codes
    task automatic issue_random_program(input int count);
        int unsigned pick;
        logic [ACTION_W-1:0] act;

        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 22)
                act = ACT_LOAD;
            else if (pick < 27)
                act = ACTION_W'($urandom_range(ACT_NONE_FIRST, ACT_NONE_LAST));
            else
                act = ACTION_W'($urandom_range(ACT_READ, ACT_XCHG));
            issue_instr(act, REG_FIELD_W'($urandom_range(0, REG_COUNT - 1)),
                        REG_FIELD_W'($urandom_range(0, REG_COUNT - 1)), pick_value());
        end
    endtask

    // Corner instructions: extremes, every action, the division special cases
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        issue_instr(ACT_LOAD, 2'd0, 2'd3, ~INT_MIN);
        issue_instr(ACT_LOAD, 2'd1, 2'd2, INT_MIN);
        issue_instr(ACT_LOAD, 2'd2, 2'd1, ALL_ONES);
        issue_instr(ACT_LOAD, 2'd3, 2'd0, '0);
        issue_instr(ACT_DIV,  2'd1, 2'd2, $urandom);   // overflow, keeps INT_MIN
        issue_instr(ACT_MOD,  2'd1, 2'd2, $urandom);   // overflow, writes zero
        issue_instr(ACT_DIV,  2'd0, 2'd3, $urandom);   // divide by zero
        issue_instr(ACT_MOD,  2'd2, 2'd3, $urandom);   // modulo by zero
        issue_instr(ACT_READ, 2'd0, 2'd1, ALL_ONES);
        issue_instr(ACT_ADD,  2'd0, 2'd0, $urandom);   // same register, wraps
        issue_instr(ACT_SUB,  2'd3, 2'd0, $urandom);
        issue_instr(ACT_MUL,  2'd0, 2'd2, $urandom);
        issue_instr(ACT_AND,  2'd2, 2'd0, $urandom);
        issue_instr(ACT_OR,   2'd3, 2'd2, $urandom);
        issue_instr(ACT_XOR,  2'd1, 2'd2, $urandom);
        issue_instr(ACT_MOVE, 2'd1, 2'd0, $urandom);
        issue_instr(ACT_XCHG, 2'd0, 2'd3, $urandom);
        issue_instr(ACT_XCHG, 2'd2, 2'd2, $urandom);   // same register, no change
        issue_instr(ACT_NONE_FIRST, 2'd1, 2'd3, $urandom);
        issue_instr(ACT_NONE_LAST,  2'd3, 2'd3, ALL_ONES);
        issue_instr(ACT_LOAD, 2'd3, 2'd0, -32'sd7);
        issue_instr(ACT_LOAD, 2'd2, 2'd0, 32'sd2);
        issue_instr(ACT_MOD,  2'd3, 2'd2, $urandom);   // negative dividend
        issue_instr(ACT_READ, 2'd3, 2'd0, '0);
        issue_instr(ACT_READ, 2'd1, 2'd0, '0);
    endtask

    task automatic test_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        issue_random_program(200);
    endtask

    task automatic test_sender_idle();
        send_idle_pct  = 87;
        recv_stall_pct = 0;
        issue_random_program(150);
    endtask

    task automatic test_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        issue_random_program(150);
    endtask

    task automatic test_both_idle();
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        issue_random_program(150);
    endtask

    // Hold ready low while the sender keeps pushing, so the input backs up
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_req    = 1'b1;
        issue_random_program(100);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.action    = '0;
        cmd_if.dest_reg  = '0;
        cmd_if.src_reg   = '0;
        cmd_if.immediate = '0;
        res_if.ready     = 1'b0;
        mismatch_count   = 0;
        quiet_cycles     = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        holdoff_left     = 0;
        holdoff_req      = 1'b0;
        foreach (arch_regs[i]) arch_regs[i] = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();

        // Drain outstanding results, then let the back end settle
        cmd_if.valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
design/fram_pkg.sv
design/fram_if.sv
design/fram_front.sv
design/fram_queue.sv
design/fram_div.sv
design/fram_back.sv
design/four_register_alu_machine_top.sv
dv/four_register_alu_machine_top_tb.sv
